>>> rtl/art_pkg.sv
// ----------------------------------------------------------------------------
// art_pkg
// Shared types and constants of the address resolution table: table depth,
// field widths, status codes and the request and response records.
// ----------------------------------------------------------------------------
package art_pkg;

    // table depth and derived widths
    localparam int ENTRIES = 16;
    localparam int POS_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = $clog2(ENTRIES + 1);

    // field widths
    localparam int IP_W     = 32;
    localparam int MAC_W    = 48;
    localparam int INDEX_W  = 4;
    localparam int STATUS_W = 3;

    // packed stream widths, rounded up to whole bytes
    localparam int IN_BITS  = 1 + IP_W + MAC_W;
    localparam int OUT_BITS = STATUS_W + INDEX_W + MAC_W;
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    // request kinds
    localparam logic OP_LEARN  = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_UPDATED = 3'd0,
        ST_ADDED   = 3'd1,
        ST_FULL    = 3'd2,
        ST_HIT     = 3'd3,
        ST_MISS    = 3'd4
    } status_t;

    // one request beat
    typedef struct packed {
        logic [MAC_W-1:0] mac_address;
        logic [IP_W-1:0]  ip_address;
        logic             opcode;
    } req_t;

    // one response beat
    typedef struct packed {
        logic [MAC_W-1:0]   found_mac;
        logic [INDEX_W-1:0] entry_index;
        status_t            status;
    } resp_t;

endpackage

>>> rtl/art_core.sv
// ----------------------------------------------------------------------------
// art_core
// Table engine: holds the address and hardware address memories, scans the
// filled entries one per cycle, then updates, appends or reads back.
// ----------------------------------------------------------------------------
module art_core
(
    input  logic          clk,
    input  logic          rst_n,
    input  art_pkg::req_t req,
    input  logic          req_valid,
    output logic          req_ready,
    output art_pkg::resp_t resp,
    output logic          resp_valid,
    input  logic          resp_ready
);
    import art_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_MAC,
        S_RESP
    } state_t;

    // memories
    logic [IP_W-1:0]  ip_mem  [ENTRIES];
    logic [MAC_W-1:0] mac_mem [ENTRIES];

    // registers
    state_t           state_reg,     state_next;
    req_t             req_reg,       req_next;
    logic [CNT_W-1:0] fill_reg,      fill_next;
    logic [CNT_W-1:0] rd_ptr_reg,    rd_ptr_next;
    logic             cmp_valid_reg, cmp_valid_next;
    logic [POS_W-1:0] cmp_ptr_reg,   cmp_ptr_next;
    resp_t            resp_reg,      resp_next;
    logic [IP_W-1:0]  ip_q_reg;
    logic [MAC_W-1:0] mac_q_reg;

    // memory port controls
    logic             ip_we;
    logic             mac_we;
    logic [POS_W-1:0] wr_addr;
    logic [POS_W-1:0] rd_addr;

    logic match;
    logic more;
    logic full;

    assign rd_addr = rd_ptr_reg[POS_W-1:0];
    assign match   = cmp_valid_reg && (ip_q_reg == req_reg.ip_address);
    assign more    = rd_ptr_reg < fill_reg;
    assign full    = fill_reg == CNT_W'(ENTRIES);

    assign req_ready  = state_reg == S_IDLE;
    assign resp_valid = state_reg == S_RESP;
    assign resp       = resp_reg;

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        fill_next      = fill_reg;
        rd_ptr_next    = rd_ptr_reg;
        cmp_valid_next = cmp_valid_reg;
        cmp_ptr_next   = cmp_ptr_reg;
        resp_next      = resp_reg;
        ip_we          = 1'b0;
        mac_we         = 1'b0;
        wr_addr        = cmp_ptr_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    req_next       = req;
                    rd_ptr_next    = '0;
                    cmp_valid_next = 1'b0;
                    state_next     = S_SCAN;
                end
            end

            S_SCAN:
            begin
                if (match)
                begin
                    // first matching entry wins
                    cmp_valid_next = 1'b0;
                    if (req_reg.opcode == OP_LEARN)
                    begin
                        mac_we     = 1'b1;
                        resp_next  = '{found_mac: '0,
                                      entry_index: INDEX_W'(cmp_ptr_reg),
                                      status: ST_UPDATED};
                        state_next = S_RESP;
                    end
                    else
                    begin
                        state_next = S_MAC;
                    end
                end
                else if (more)
                begin
                    // issue the next entry read, compare it next cycle
                    cmp_valid_next = 1'b1;
                    cmp_ptr_next   = rd_addr;
                    rd_ptr_next    = rd_ptr_reg + 1'b1;
                end
                else
                begin
                    // every filled entry checked without a match
                    cmp_valid_next = 1'b0;
                    state_next     = S_RESP;
                    if (req_reg.opcode == OP_LOOKUP)
                    begin
                        resp_next = '{found_mac: '0, entry_index: '0, status: ST_MISS};
                    end
                    else if (full)
                    begin
                        resp_next = '{found_mac: '0, entry_index: '0, status: ST_FULL};
                    end
                    else
                    begin
                        ip_we     = 1'b1;
                        mac_we    = 1'b1;
                        wr_addr   = fill_reg[POS_W-1:0];
                        fill_next = fill_reg + 1'b1;
                        resp_next = '{found_mac: '0,
                                      entry_index: INDEX_W'(fill_reg[POS_W-1:0]),
                                      status: ST_ADDED};
                    end
                end
            end

            S_MAC:
            begin
                // hardware address of the hit entry is now in the read register
                resp_next  = '{found_mac: mac_q_reg,
                              entry_index: INDEX_W'(cmp_ptr_reg),
                              status: ST_HIT};
                state_next = S_RESP;
            end

            S_RESP:
            begin
                if (resp_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            rd_ptr_reg    <= '0;
            cmp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            rd_ptr_reg    <= rd_ptr_next;
            cmp_valid_reg <= cmp_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        req_reg     <= req_next;
        cmp_ptr_reg <= cmp_ptr_next;
        resp_reg    <= resp_next;
    end

    // address memory, one write and one registered read
    always_ff @(posedge clk)
    begin
        if (ip_we)
        begin
            ip_mem[wr_addr] <= req_reg.ip_address;
        end
        ip_q_reg <= ip_mem[rd_addr];
    end

    // hardware address memory, read at the last compared entry
    always_ff @(posedge clk)
    begin
        if (mac_we)
        begin
            mac_mem[wr_addr] <= req_reg.mac_address;
        end
        mac_q_reg <= mac_mem[cmp_ptr_reg];
    end

endmodule

>>> rtl/address_resolution_table.sv
// ----------------------------------------------------------------------------
// address_resolution_table
// Cache of IPv4 to hardware address pairs with learn and lookup requests.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_axis channel, one beat per request: a learn
//   stores or refreshes a pair, a lookup returns the stored hardware address.
//   Every request gives exactly one response beat on the m_axis channel,
//   in request order, with a status, the table position and the address.
//   Entries fill in order from position 0; a learn of a new address into a
//   full table is dropped and reported with the full status.
// Timing:
//   The filled entries are scanned one per cycle through the registered read
//   port of the address memory. The engine takes the next request as soon
//   as the response is in the output register. One request waits in the
//   input buffer while the engine works.
// Reset and stall:
//   Reset empties the table (fill count zero) and drops any pending beat.
//   While m_axis_tready is low the response holds in the output register,
//   the engine waits with the next response and then backpressures input.
// ----------------------------------------------------------------------------
module address_resolution_table
(
    input  logic                      clk,
    input  logic                      rst_n,
    // opcode [0], ip_address [32:1], mac_address [80:33], zero fill above
    input  logic [art_pkg::IN_W-1:0]  s_axis_tdata,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // status [2:0], entry_index [6:3], found_mac [54:7], zero fill above
    output logic [art_pkg::OUT_W-1:0] m_axis_tdata,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready
);
    import art_pkg::*;

    logic  in_valid_reg;
    req_t  in_data_reg;
    logic  core_ready;
    resp_t core_resp;
    logic  core_resp_valid;
    logic  core_resp_ready;
    logic  out_valid_reg;
    resp_t out_data_reg;

    // input buffer
    assign s_axis_tready = !in_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tvalid && s_axis_tready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (core_ready)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_data_reg <= s_axis_tdata[IN_BITS-1:0];
        end
    end

    art_core u_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (in_data_reg),
        .req_valid  (in_valid_reg),
        .req_ready  (core_ready),
        .resp       (core_resp),
        .resp_valid (core_resp_valid),
        .resp_ready (core_resp_ready)
    );

    // output register
    assign core_resp_ready = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (core_resp_ready)
        begin
            out_valid_reg <= core_resp_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (core_resp_ready && core_resp_valid)
        begin
            out_data_reg <= core_resp;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_W'(out_data_reg);

endmodule
